// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Control characters
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_LF  = 8'd10;

  localparam logic [7:0]  SPACE_CHAR = 8'h20;
  localparam logic [15:0] CLEAR_CELL = 16'h0720;
  localparam logic [7:0]  ATTR_RESET = 8'h07;
  localparam int          TAB_STEP   = 4;

  // Item mode
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_BLANK,
    S_EMIT
  } tcw_state_t;

  // Put decision for one character, cursor values at output field widths
  typedef struct packed {
    logic       write;
    logic       scroll;
    logic [7:0] ch;
    logic [6:0] cur_col;
    logic [4:0] cur_row;
    logic [6:0] nxt_col;
    logic [4:0] nxt_row;
  } tcw_put_t;

endpackage

// ===== rtl/core/text_console_character_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_writer
// Text-mode console: character grid in one RAM, cursor, scroll engine.
// ----------------------------------------------------------------------------
// Usage:
//  Input beats on s_* carry a put (mode 0) or a cell read (mode 1). Each beat
//  gives exactly one result beat on m_*: the cell read (0 for puts and reads
//  outside the grid), the cursor after the item and the scroll flag.
//  One item is in work at a time; s_tready is high only when idle.
//  A put without scroll goes from IDLE to EMIT; a read goes through READ to EMIT.
//  A put that scrolls walks the whole grid through the RAM, one cell per
//  cycle, in SHIFT and then BLANK, before EMIT. The single read port of the
//  cell RAM sets this pace.
//  After reset the grid RAM is swept to spaces with attribute 07, one cell a
//  cycle, while s_tready stays low; cfg writes are taken at any time and
//  set the attribute of written or blanked cells.
//  A result waits in the output register while m_tready is low; the block
//  still takes a new beat and holds that item in EMIT until the register frees.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  // config write: text attribute
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero
  input  logic [0:0]  s_tuser,   // mode[0]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cell_value[15:0], cursor_col[22:16],
                                 // cursor_row[27:23], scrolled[28], zero
);

  localparam int DEPTH   = ROWS * COLUMNS;
  localparam int AW      = $clog2(DEPTH);
  localparam int SHIFT_N = (ROWS - 1) * COLUMNS;

  tcw_pkg::tcw_state_t state, state_next;
  logic [AW-1:0]       ptr, ptr_next;

  logic [7:0]  attr;
  logic        accept;
  logic        out_free;
  logic        mode;
  logic [7:0]  char_code;
  logic [4:0]  read_row;
  logic [6:0]  read_col;
  logic        rd_in_range;
  logic [AW-1:0] rd_addr_in;

  tcw_pkg::tcw_put_t put;
  logic [AW-1:0]     put_addr;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;

  logic [15:0] res_cell;
  logic [6:0]  res_col;
  logic [4:0]  res_row;
  logic        res_scroll;
  logic        read_hit;

  assign mode      = s_tuser[0];
  assign char_code = s_tdata[7:0];
  assign read_row  = s_tdata[12:8];
  assign read_col  = s_tdata[19:13];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == tcw_pkg::S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  assign rd_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
  assign rd_addr_in  = AW'(read_row) * AW'(COLUMNS) + AW'(read_col);

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .step      (accept && (mode == tcw_pkg::MODE_PUT)),
    .char_code (char_code),
    .put       (put),
    .addr      (put_addr)
  );

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    we         = 1'b0;
    waddr      = ptr;
    wdata      = tcw_pkg::CLEAR_CELL;
    re         = 1'b0;
    raddr      = ptr + AW'(COLUMNS);
    case (state)
      tcw_pkg::S_CLEAR: begin
        we = 1'b1;
        if (ptr == AW'(DEPTH - 1)) begin
          ptr_next   = '0;
          state_next = tcw_pkg::S_IDLE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      tcw_pkg::S_IDLE: begin
        if (accept) begin
          ptr_next = '0;
          if (mode == tcw_pkg::MODE_READ) begin
            re         = rd_in_range;
            raddr      = rd_addr_in;
            state_next = tcw_pkg::S_READ;
          end else begin
            we         = put.write;
            waddr      = put_addr;
            wdata      = {attr, put.ch};
            state_next = put.scroll ? tcw_pkg::S_SHIFT : tcw_pkg::S_EMIT;
          end
        end
      end
      tcw_pkg::S_READ: begin
        state_next = tcw_pkg::S_EMIT;
      end
      tcw_pkg::S_SHIFT: begin
        // read one row down, write back the cell fetched last cycle
        re    = (ptr < AW'(SHIFT_N));
        we    = (ptr != '0);
        waddr = ptr - AW'(1);
        wdata = rdata;
        if (ptr == AW'(SHIFT_N)) begin
          state_next = tcw_pkg::S_BLANK;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      tcw_pkg::S_BLANK: begin
        we    = 1'b1;
        wdata = {attr, tcw_pkg::SPACE_CHAR};
        if (ptr == AW'(DEPTH - 1)) begin
          ptr_next   = '0;
          state_next = tcw_pkg::S_EMIT;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      tcw_pkg::S_EMIT: begin
        if (out_free) begin
          state_next = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::S_CLEAR;
      ptr      <= '0;
      attr     <= tcw_pkg::ATTR_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      if (cfg_valid && cfg_ready) begin
        attr <= cfg_data;
      end
      if ((state == tcw_pkg::S_EMIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_cell <= '0;
      read_hit <= (mode == tcw_pkg::MODE_READ) && rd_in_range;
      if (mode == tcw_pkg::MODE_READ) begin
        res_col    <= put.cur_col;
        res_row    <= put.cur_row;
        res_scroll <= 1'b0;
      end else begin
        res_col    <= put.nxt_col;
        res_row    <= put.nxt_row;
        res_scroll <= put.scroll;
      end
    end
    if (state == tcw_pkg::S_READ) begin
      res_cell <= read_hit ? rdata : '0;
    end
    if ((state == tcw_pkg::S_EMIT) && out_free) begin
      m_tdata <= {3'b000, res_scroll, res_row, res_col, res_cell};
    end
  end

endmodule

// ===== rtl/core/tcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/tcw_cursor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor register and the put decision: target cell, new cursor, scroll.
// ----------------------------------------------------------------------------
module tcw_cursor #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [7:0]                       char_code,
  output tcw_pkg::tcw_put_t                put,
  output logic [$clog2(ROWS*COLUMNS)-1:0]  addr
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);
  localparam int TW = CW + 3;
  localparam int UW = RW + 1;
  localparam int AW = $clog2(ROWS*COLUMNS);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [TW-1:0] col_t;
  logic [UW-1:0] row_t;
  logic [CW-1:0] wr_col;
  logic [RW-1:0] wr_row;
  logic [CW-1:0] col_f;
  logic [RW-1:0] row_f;
  logic          write;
  logic          scroll;
  logic [7:0]    ch;

  always_comb begin
    col_t  = TW'(col);
    row_t  = UW'(row);
    wr_col = col;
    wr_row = row;
    write  = 1'b0;
    ch     = char_code;
    case (char_code)
      tcw_pkg::CH_LF: begin
        col_t = '0;
        row_t = UW'(row) + UW'(1);
      end
      tcw_pkg::CH_TAB: begin
        col_t = TW'(col) + TW'(tcw_pkg::TAB_STEP);
      end
      tcw_pkg::CH_BS: begin
        // step back, wrapping to the end of the previous row; stay at home
        if (col != '0) begin
          col_t  = TW'(col) - TW'(1);
          wr_col = col - CW'(1);
        end else if (row != '0) begin
          col_t  = TW'(COLUMNS - 1);
          row_t  = UW'(row) - UW'(1);
          wr_col = CW'(COLUMNS - 1);
          wr_row = row - RW'(1);
        end
        write = 1'b1;
        ch    = tcw_pkg::SPACE_CHAR;
      end
      default: begin
        write = 1'b1;
        col_t = TW'(col) + TW'(1);
      end
    endcase

    if (col_t >= TW'(COLUMNS)) begin
      col_t = '0;
      row_t = row_t + UW'(1);
    end

    scroll = (row_t >= UW'(ROWS));
    col_f  = col_t[CW-1:0];
    row_f  = scroll ? RW'(ROWS - 1) : row_t[RW-1:0];
  end

  assign addr = AW'(wr_row) * AW'(COLUMNS) + AW'(wr_col);

  assign put.write   = write;
  assign put.scroll  = scroll;
  assign put.ch      = ch;
  assign put.cur_col = 7'(col);
  assign put.cur_row = 5'(row);
  assign put.nxt_col = 7'(col_f);
  assign put.nxt_row = 5'(row_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      col <= col_f;
      row <= row_f;
    end
  end

endmodule
